// ===== hdl/ilst_pkg.sv =====
package ilst_pkg;

   // Fixed widths of the transfer fields
   localparam int KIND_W   = 3;
   localparam int POS_W    = 7;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 3;
   localparam int FIDX_W   = 6;
   localparam int COUNT_W  = 7;

   // Match flags searched at once by the first-match scan
   localparam int SCAN_GROUP = 8;

   typedef logic [POS_W-1:0]          position_type;
   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [FIDX_W-1:0]         found_index_type;
   typedef logic [COUNT_W-1:0]        count_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT     = 3'd0,
      KIND_ERASE      = 3'd1,
      KIND_FIND       = 3'd2,
      KIND_MODIFY     = 3'd3,
      KIND_PUSH_BACK  = 3'd4,
      KIND_PUSH_FRONT = 3'd5,
      KIND_POP_BACK   = 3'd6,
      KIND_POP_FRONT  = 3'd7
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 3'd0,
      STATUS_BAD_POS   = 3'd1,
      STATUS_FULL      = 3'd2,
      STATUS_NOT_FOUND = 3'd3,
      STATUS_EMPTY     = 3'd4
   } status_type;

   // What every cell of the row does on one clock
   typedef enum logic [1:0] {
      CELL_HOLD       = 2'd0,
      CELL_SHIFT_UP   = 2'd1,
      CELL_SHIFT_DOWN = 2'd2,
      CELL_WRITE      = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        match_en;
   } cell_ctl_type;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_SCAN = 1'b1
   } fsm_state_type;

   typedef struct packed {
      status_type      status;
      found_index_type found_index;
      count_type       count;
   } result_type;

endpackage

// ===== hdl/ilst_req_if.sv =====
interface ilst_req_if;
   import ilst_pkg::*;

   logic         valid;
   logic         ready;
   kind_type     kind;
   position_type position;
   value_type    value;

   modport source (output valid, output kind, output position, output value, input ready);
   modport sink   (input valid, input kind, input position, input value, output ready);

endinterface

// ===== hdl/ilst_rsp_if.sv =====
interface ilst_rsp_if;
   import ilst_pkg::*;

   logic            valid;
   logic            ready;
   status_type      status;
   found_index_type found_index;
   count_type       count;

   modport source (output valid, output status, output found_index, output count, input ready);
   modport sink   (input valid, input status, input found_index, input count, output ready);

endinterface

// ===== hdl/ilst_cell.sv =====
module ilst_cell #(
   parameter int DATA_WIDTH = 32,
   parameter int CNT_W      = 7,
   parameter int INDEX      = 0
) (
   input  logic                   clock,
   input  ilst_pkg::cell_ctl_type ctl,
   input  logic [CNT_W-1:0]       pos,
   input  logic [CNT_W-1:0]       count,
   input  logic [DATA_WIDTH-1:0]  key,
   input  logic [DATA_WIDTH-1:0]  left_data,
   input  logic [DATA_WIDTH-1:0]  right_data,
   output logic [DATA_WIDTH-1:0]  entry,
   output logic                   match
);
   import ilst_pkg::*;

   localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

   logic [DATA_WIDTH-1:0] entry_ff;
   logic [DATA_WIDTH-1:0] entry_in;
   logic                  match_ff;
   logic                  match_in;

   // Pick the next entry from self, a neighbour or the key
   always_comb begin
      entry_in = entry_ff;
      unique case (ctl.op)
         CELL_HOLD: begin
            entry_in = entry_ff;
         end
         CELL_SHIFT_UP: begin
            if (IDX > pos) begin
               entry_in = left_data;
            end else if (IDX == pos) begin
               entry_in = key;
            end
         end
         CELL_SHIFT_DOWN: begin
            if (IDX >= pos) begin
               entry_in = right_data;
            end
         end
         CELL_WRITE: begin
            if (IDX == pos) begin
               entry_in = key;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   // Flag a live entry equal to the key
   assign match_in = ctl.match_en ? ((entry_ff == key) && (IDX < count)) : match_ff;

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      match_ff <= match_in;
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule

// ===== hdl/indexed_sequential_list.sv =====
// Channel   Port      Direction  Payload
// request   req_chan  in         kind, position, value
// response  rsp_chan  out        status, found_index, count
//
// Insert, erase, modify, push and pop finish on the transfer edge: every cell of the row
// shifts or writes on the transfer edge and the result is registered there.
// Find: the cells flag matches on the transfer edge, then one group of eight flags
// is searched per cycle until a match or the last group.
// Reset clears the count and the control; entries need no clearing.
// A result that cannot leave waits in a skid register; requests stall only
// while a find is scanning or the skid register is occupied.
module indexed_sequential_list #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input logic     clock,
   input logic     reset,
   ilst_req_if.sink   req_chan,
   ilst_rsp_if.source rsp_chan
);
   import ilst_pkg::*;

   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CMP_W  = (POS_W > CNT_W) ? POS_W : CNT_W;
   localparam int NGROUP = (DEPTH + SCAN_GROUP - 1) / SCAN_GROUP;
   localparam int NPAD   = NGROUP * SCAN_GROUP;
   localparam int GRP_W  = (NGROUP > 1) ? $clog2(NGROUP) : 1;
   localparam int SUB_W  = $clog2(SCAN_GROUP);

   fsm_state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [GRP_W-1:0] grp_ff, grp_in;

   result_type out_ff, out_in, pend_ff, pend_in;
   logic       rsp_valid_ff, rsp_valid_in, pend_valid_ff, pend_valid_in;

   cell_ctl_type          ctl;
   logic [CNT_W-1:0]      cmd_pos;
   logic [DATA_WIDTH-1:0] key;
   logic [DATA_WIDTH-1:0] entry_bus [DEPTH];
   logic [NPAD-1:0]       match_pad;

   logic             req_fire;
   logic             out_free;
   logic             res_valid;
   result_type       res;
   logic [CMP_W-1:0] pos_ext, count_ext;
   logic             is_full, is_empty;
   logic [SCAN_GROUP-1:0] grp_bits;
   logic             grp_hit;
   logic [SUB_W-1:0] grp_sub;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign key      = DATA_WIDTH'(req_chan.value);
   assign pos_ext  = CMP_W'(req_chan.position);
   assign count_ext = CMP_W'(count_ff);
   assign is_full  = (count_ff == CNT_W'(DEPTH));
   assign is_empty = (count_ff == '0);

   // Row of cells, each handing its entry to its neighbours
   for (genvar i = 0; i < NPAD; i++) begin : g_row
      if (i < DEPTH) begin : g_cell
         logic [DATA_WIDTH-1:0] left_data, right_data;
         if (i == 0) begin : g_first
            assign left_data = '0;
         end else begin : g_left
            assign left_data = entry_bus[i-1];
         end
         if (i == DEPTH - 1) begin : g_last
            assign right_data = '0;
         end else begin : g_right
            assign right_data = entry_bus[i+1];
         end
         ilst_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CNT_W      (CNT_W),
            .INDEX      (i)
         ) u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .pos        (cmd_pos),
            .count      (count_ff),
            .key        (key),
            .left_data  (left_data),
            .right_data (right_data),
            .entry      (entry_bus[i]),
            .match      (match_pad[i])
         );
      end else begin : g_pad
         assign match_pad[i] = 1'b0;
      end
   end

   // Search the current group of match flags, lowest index first
   assign grp_bits = match_pad[grp_ff * SCAN_GROUP +: SCAN_GROUP];
   always_comb begin
      grp_hit = 1'b0;
      grp_sub = '0;
      for (int k = SCAN_GROUP - 1; k >= 0; k--) begin
         if (grp_bits[k]) begin
            grp_hit = 1'b1;
            grp_sub = SUB_W'(k);
         end
      end
   end

   // Decode the request, drive the cells and form the result
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      grp_in     = grp_ff;
      ctl.op     = CELL_HOLD;
      ctl.match_en = 1'b0;
      cmd_pos    = '0;
      res_valid  = 1'b0;
      res.status = STATUS_OK;
      res.found_index = '0;
      res.count  = COUNT_W'(count_ff);

      unique case (state_ff)
         FSM_IDLE: begin
            if (req_fire) begin
               res_valid = 1'b1;
               unique case (req_chan.kind)
                  KIND_INSERT: begin
                     if (pos_ext > count_ext) begin
                        res.status = STATUS_BAD_POS;
                     end else if (is_full) begin
                        res.status = STATUS_FULL;
                     end else begin
                        ctl.op   = CELL_SHIFT_UP;
                        cmd_pos  = CNT_W'(pos_ext);
                        count_in = CNT_W'(count_ff + 1'b1);
                     end
                  end
                  KIND_ERASE: begin
                     if (pos_ext >= count_ext) begin
                        res.status = STATUS_BAD_POS;
                     end else begin
                        ctl.op   = CELL_SHIFT_DOWN;
                        cmd_pos  = CNT_W'(pos_ext);
                        count_in = CNT_W'(count_ff - 1'b1);
                     end
                  end
                  KIND_FIND: begin
                     res_valid    = 1'b0;
                     ctl.match_en = 1'b1;
                     grp_in       = '0;
                     state_in     = FSM_SCAN;
                  end
                  KIND_MODIFY: begin
                     if (pos_ext >= count_ext) begin
                        res.status = STATUS_BAD_POS;
                     end else begin
                        ctl.op  = CELL_WRITE;
                        cmd_pos = CNT_W'(pos_ext);
                     end
                  end
                  KIND_PUSH_BACK: begin
                     if (is_full) begin
                        res.status = STATUS_FULL;
                     end else begin
                        ctl.op   = CELL_SHIFT_UP;
                        cmd_pos  = count_ff;
                        count_in = CNT_W'(count_ff + 1'b1);
                     end
                  end
                  KIND_PUSH_FRONT: begin
                     if (is_full) begin
                        res.status = STATUS_FULL;
                     end else begin
                        ctl.op   = CELL_SHIFT_UP;
                        count_in = CNT_W'(count_ff + 1'b1);
                     end
                  end
                  KIND_POP_BACK: begin
                     if (is_empty) begin
                        res.status = STATUS_EMPTY;
                     end else begin
                        ctl.op   = CELL_SHIFT_DOWN;
                        cmd_pos  = CNT_W'(count_ff - 1'b1);
                        count_in = CNT_W'(count_ff - 1'b1);
                     end
                  end
                  KIND_POP_FRONT: begin
                     if (is_empty) begin
                        res.status = STATUS_EMPTY;
                     end else begin
                        ctl.op   = CELL_SHIFT_DOWN;
                        count_in = CNT_W'(count_ff - 1'b1);
                     end
                  end
                  default: begin
                     res_valid = 1'b0;
                  end
               endcase
               res.count = COUNT_W'(count_in);
            end
         end
         FSM_SCAN: begin
            if (grp_hit) begin
               res_valid       = 1'b1;
               res.found_index = FIDX_W'({grp_ff, grp_sub});
               state_in        = FSM_IDLE;
            end else if (grp_ff == GRP_W'(NGROUP - 1)) begin
               res_valid  = 1'b1;
               res.status = STATUS_NOT_FOUND;
               state_in   = FSM_IDLE;
            end else begin
               grp_in = GRP_W'(grp_ff + 1'b1);
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // Steer results through the output register and the skid register
   always_comb begin
      out_in        = out_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff;
      pend_valid_in = pend_valid_ff;
      priority if (pend_valid_ff && out_free) begin
         out_in        = pend_ff;
         rsp_valid_in  = 1'b1;
         pend_valid_in = 1'b0;
      end else if (res_valid && out_free) begin
         out_in       = res;
         rsp_valid_in = 1'b1;
      end else if (res_valid) begin
         pend_in       = res;
         pend_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= FSM_IDLE;
         count_ff      <= '0;
         grp_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         grp_ff        <= grp_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      pend_ff <= pend_in;
   end

   assign req_chan.ready       = (state_ff == FSM_IDLE) && !pend_valid_ff;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = out_ff.status;
   assign rsp_chan.found_index = out_ff.found_index;
   assign rsp_chan.count       = out_ff.count;

`ifndef NO_ASSERTIONS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> rsp_valid_ff)
      else $error("skid register holds a result while the output is empty");

   a_no_accept_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_SCAN) |-> !req_chan.ready)
      else $error("request taken during a find scan");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count beyond depth");

   a_quick_result: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_chan.kind != KIND_FIND)) |=> rsp_chan.valid)
      else $error("single-cycle operation gave no result");
`endif

endmodule
